@@ rtl/ppl_cov_pkg.sv @@
// Shared constants, types and helpers for the point and line coverage block.
package ppl_cov_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int COORD_BITS = 12;
    localparam int SLOT_BITS  = 4;
    localparam int DEPTH_BITS = 16;
    localparam int COLOR_BITS = 24;
    localparam int PIX_BITS   = 11;
    localparam int KIND_BITS  = 2;
    // Wide enough for the error term 2*|dx*dy'-dy*dx'| of any coordinates
    localparam int PROD_BITS  = 2 * (COORD_BITS + 2) + 2;

    localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_POINT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_LINE  = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Load or query token that ripples down the chain of cells
    typedef struct packed {
        logic                           valid;
        logic                           query;
        logic [SLOT_BITS-1:0]           slot;
        logic [KIND_BITS-1:0]           kind;
        coord_t                         ax;
        coord_t                         ay;
        logic signed [DEPTH_BITS-1:0]   az;
        coord_t                         bx;
        coord_t                         by;
        logic [COLOR_BITS-1:0]          prim_color;
        logic [PIX_BITS-1:0]            px;
        logic [PIX_BITS-1:0]            py;
        logic [COLOR_BITS-1:0]          bg_color;
        logic                           found;
        logic                           best_point;
        logic signed [DEPTH_BITS-1:0]   best_depth;
        logic [COLOR_BITS-1:0]          best_color;
    } token_t;

endpackage

@@ rtl/pixel_point_line_coverage.sv @@
// Top level of the per-pixel point and line coverage block.
// Usage:
//   A transfer is taken at each rising edge with start high; busy stays low,
//   so one load or query enters every cycle.
//   cmd=0 loads slot 'slot' with a point (kind 1), line (kind 2) or empties it.
//   cmd=1 queries pixel (pixel_x, pixel_y) with background bg_color.
//   Items travel down a chain of NUM_SLOTS cells, one per table slot, each with
//   a compare/multiply stage, then a distance test and depth select stage.
//   A load updates its slot as it passes, so later items see it in order.
//   Throughput: one item per cycle.
//   Each query yields one result with done high for one cycle; loads yield
//   none. The receiver cannot stall: results are shown once.
//   Reset empties every slot and clears the chain; stored coordinates,
//   depths and colors are not reset.
module pixel_point_line_coverage
    import ppl_cov_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [SLOT_BITS-1:0]         slot,
    input  logic [KIND_BITS-1:0]         kind,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [DEPTH_BITS-1:0] az,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic [COLOR_BITS-1:0]        prim_color,
    input  logic [PIX_BITS-1:0]          pixel_x,
    input  logic [PIX_BITS-1:0]          pixel_y,
    input  logic [COLOR_BITS-1:0]        bg_color,
    output logic                         done,
    output logic [COLOR_BITS-1:0]        pixel_color,
    output logic                         covered
);

    token_t chain [NUM_SLOTS+1];

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid      = start;
        chain[0].query      = cmd;
        chain[0].slot       = slot;
        chain[0].kind       = kind;
        chain[0].ax         = ax;
        chain[0].ay         = ay;
        chain[0].az         = az;
        chain[0].bx         = bx;
        chain[0].by         = by;
        chain[0].prim_color = prim_color;
        chain[0].px         = pixel_x;
        chain[0].py         = pixel_y;
        chain[0].bg_color   = bg_color;
        chain[0].found      = 1'b0;
        chain[0].best_point = 1'b0;
        chain[0].best_depth = '0;
        chain[0].best_color = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            ppl_cov_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .my_slot (SLOT_BITS'(g)),
                .tok_in  (chain[g]),
                .tok_out (chain[g+1])
            );
        end
    endgenerate

    logic done_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic covered_reg;
    token_t last;

    assign last = chain[NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid && (last.query == CMD_QUERY);
    end

    always_ff @(posedge clk)
    begin
        color_reg   <= last.found ? last.best_color : last.bg_color;
        covered_reg <= last.found;
    end

    assign done        = done_reg;
    assign pixel_color = color_reg;
    assign covered     = covered_reg;

endmodule

@@ rtl/ppl_cov_cell.sv @@
// One slot of the primitive table plus its two-stage coverage test.
module ppl_cov_cell
    import ppl_cov_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SLOT_BITS-1:0] my_slot,
    input  token_t               tok_in,
    output token_t               tok_out
);

    localparam int DB = COORD_BITS + 2;

    logic [KIND_BITS-1:0] kind_reg;
    coord_t x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DEPTH_BITS-1:0] depth_reg;
    logic [COLOR_BITS-1:0] color_reg;

    // stage 1 registers and the stage 2 output token
    token_t t1_reg;
    logic   pt_hit_reg, ln_simple_reg, ln_box_reg;
    logic signed [PROD_BITS-1:0] p1_reg, p2_reg;
    logic [DB-1:0] adx_reg;
    token_t tok_reg;

    logic load_me;
    logic [KIND_BITS-1:0] kind_st;
    logic swap;

    always_comb
    begin
        load_me = tok_in.valid && (tok_in.query == CMD_LOAD) && (tok_in.slot == my_slot);
        kind_st = (tok_in.kind == KIND_POINT || tok_in.kind == KIND_LINE) ? tok_in.kind
                                                                        : KIND_EMPTY;
        swap    = (kind_st == KIND_LINE) && !(tok_in.ax < tok_in.bx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_EMPTY;
        else if (load_me)
            kind_reg <= kind_st;
    end

    always_ff @(posedge clk)
    begin
        if (load_me)
        begin
            x1_reg    <= swap ? tok_in.bx : tok_in.ax;
            y1_reg    <= swap ? tok_in.by : tok_in.ay;
            x2_reg    <= swap ? tok_in.ax : tok_in.bx;
            y2_reg    <= swap ? tok_in.ay : tok_in.by;
            depth_reg <= tok_in.az;
            color_reg <= tok_in.prim_color;
        end
    end

    // stage 1: compare and multiply
    logic signed [DB-1:0] px_s, py_s, x1s, y1s, x2s, y2s, dx, dy, rx, ry;
    logic hz, vt, inbox;

    always_comb
    begin
        px_s = DB'($signed({1'b0, tok_in.px}));
        py_s = DB'($signed({1'b0, tok_in.py}));
        x1s  = DB'(x1_reg);
        y1s  = DB'(y1_reg);
        x2s  = DB'(x2_reg);
        y2s  = DB'(y2_reg);
        dx   = x2s - x1s;
        dy   = y2s - y1s;
        rx   = px_s - x1s;
        ry   = py_s - y1s;
        hz   = (dy == '0) && (py_s == y2s) && (px_s >= x1s) && (px_s <= x2s);
        vt   = (dx == '0) && (px_s == x2s) &&
               (((py_s >= y1s) && (py_s <= y2s)) || ((py_s >= y2s) && (py_s <= y1s)));
        inbox = (((px_s >= x1s) && (px_s <= x2s)) || ((px_s >= x2s) && (px_s <= x1s))) &&
                (((py_s >= y1s) && (py_s <= y2s)) || ((py_s >= y2s) && (py_s <= y1s)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1_reg <= '0;
        else
            t1_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        pt_hit_reg    <= (kind_reg == KIND_POINT) && (x1s == px_s) && (y1s == py_s);
        ln_simple_reg <= (kind_reg == KIND_LINE) && (hz || (!(dy == '0 && py_s == y2s) && vt));
        ln_box_reg    <= (kind_reg == KIND_LINE) && !(dy == '0 && py_s == y2s)
                         && !(dx == '0 && px_s == x2s) && inbox;
        p1_reg  <= PROD_BITS'(dx * ry);
        p2_reg  <= PROD_BITS'(dy * rx);
        adx_reg <= dx[DB-1] ? DB'(-dx) : DB'(dx);
    end

    // stage 2: distance test and depth select
    logic signed [PROD_BITS-1:0] e, ae;
    logic ln_hit;
    token_t nt;

    always_comb
    begin
        e      = p1_reg - p2_reg;
        ae     = e[PROD_BITS-1] ? -e : e;
        ln_hit = ln_simple_reg || (ln_box_reg && ((ae <<< 1) < $signed({1'b0, adx_reg})));
        nt     = t1_reg;
        if (t1_reg.valid && t1_reg.query == CMD_QUERY)
        begin
            if (pt_hit_reg && (!t1_reg.found || depth_reg > t1_reg.best_depth ||
                (!t1_reg.best_point && depth_reg == t1_reg.best_depth)))
            begin
                nt.found      = 1'b1;
                nt.best_point = 1'b1;
                nt.best_depth = depth_reg;
                nt.best_color = color_reg;
            end
            else if (ln_hit && (!t1_reg.found || t1_reg.best_depth < 0))
            begin
                nt.found      = 1'b1;
                nt.best_point = 1'b0;
                nt.best_depth = '0;
                nt.best_color = color_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= nt;
    end

    assign tok_out = tok_reg;

endmodule
